[rtl/core/lph_pkg.sv]
// Shared types and constants of the linear-probe hash insert block.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package lph_pkg;

  localparam int SLOTS         = 1024;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int SIZE_W        = 11;
  localparam int KEY_SUM_W     = 11;
  localparam int MAX_KEY_CHARS = 19;
  localparam int KEY_LEN_W     = 5;
  localparam int COUNT_W       = 11;
  localparam int PSUM_W        = 20;
  localparam int DIV_CNT_W     = $clog2(KEY_SUM_W);
  localparam int STATUS_W      = 2;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 32;

  localparam logic [COUNT_W-1:0] PLACED_MAX = {COUNT_W{1'b1}};
  localparam logic [PSUM_W-1:0]  PSUM_MAX   = {PSUM_W{1'b1}};

  localparam logic [7:0] CHAR_BASE = 8'h60;
  localparam logic [7:0] CHAR_A    = 8'h61;
  localparam logic [7:0] CHAR_Z    = 8'h7A;

  localparam logic REQ_KEY   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  localparam logic CFG_REG_TABLE_SIZE = 1'b0;
  localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = SIZE_W'(SLOTS);

  typedef enum logic [STATUS_W-1:0] {
    RES_PLACED = 2'd0,
    RES_FULL   = 2'd1,
    RES_BAD    = 2'd2
  } res_code_t;

  typedef struct packed {
    logic      key_load;
    logic      clear_start;
    logic      clr_step;
    logic      div_start;
    logic      div_step;
    logic      probe_next;
    logic      commit;
    res_code_t res;
  } lph_cmd_t;

  typedef struct packed {
    logic key_bad;
    logic div_last;
    logic slot_occ;
    logic probe_end;
    logic clr_last;
    logic out_busy;
  } lph_sts_t;

endpackage

`default_nettype wire

[rtl/core/lph_in_if.sv]
// Request channel of the hash insert block: valid/ready plus key byte payload.
// Depends on lph_pkg.
`default_nettype none

interface lph_in_if
  import lph_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] key_byte;
  logic       last_byte;

  modport source (output valid, output req_type, output key_byte, output last_byte,
                  input ready);
  modport sink   (input valid, input req_type, input key_byte, input last_byte,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/lph_out_if.sv]
// Result channel of the hash insert block: valid/ready plus insert outcome.
// Depends on lph_pkg.
`default_nettype none

interface lph_out_if
  import lph_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [SIZE_W-1:0]   probe_count;
  logic [COUNT_W-1:0]  keys_placed;
  logic [PSUM_W-1:0]   probe_total;

  modport source (output valid, output status, output slot, output probe_count,
                  output keys_placed, output probe_total, input ready);
  modport sink   (input valid, input status, input slot, input probe_count,
                  input keys_placed, input probe_total, output ready);
endinterface

`default_nettype wire

[rtl/core/linear_probe_hash_insert.sv]
// Linear-probe hash insert, top level: request and result channels, APB config port.
// Depends on lph_pkg, lph_in_if, lph_out_if, lph_ctrl and lph_dp.
//
// Usage: send a key one byte per request on in_ch (req_type key, key_byte,
// last_byte on the final byte). Each lowercase byte adds its alphabet position
// to a running sum. A non-final byte gives no result. The final byte hashes
// the sum modulo the active table size (table_size clamped to 1..1024) in a
// shift-subtract unit, walks the occupancy memory one slot at a time (a
// registered read, then a check), marks the first free slot, if any, and
// posts one result on out_ch; in_ch.ready stays low until the result is
// committed. A clear request (req_type clear) empties the table and counters;
// it and reset run a sweep over all 1024 slots of the occupancy memory, during
// which in_ch.ready stays low (APB writes are still taken). The result register
// holds while out_ch.ready is low; non-final bytes are still taken then, a
// final byte is taken but its result waits for the result register to drain,
// with in_ch.ready low meanwhile. table_size sits at byte address 0, resets to
// 1024, and must be written by the user only while idle; the block does not check.
`default_nettype none

module linear_probe_hash_insert
  import lph_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  lph_in_if.sink                 in_ch,
  lph_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  logic [SIZE_W-1:0] table_size_r, table_size_nxt;
  logic              cfg_sel_ts;
  lph_cmd_t          cmd;
  lph_sts_t          sts;
  res_code_t         out_status;

  assign cfg_sel_ts = (paddr[CFG_AW-1] == CFG_REG_TABLE_SIZE);
  assign pready     = 1'b1;
  assign prdata     = cfg_sel_ts ? CFG_DW'(table_size_r) : '0;

  always_comb begin
    table_size_nxt = table_size_r;
    if (psel && penable && pwrite && cfg_sel_ts) table_size_nxt = pwdata[SIZE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RST;
    end else begin
      table_size_r <= table_size_nxt;
    end
  end

  lph_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_req_type  (in_ch.req_type),
    .in_last_byte (in_ch.last_byte),
    .in_ready     (in_ch.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  lph_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_key_byte     (in_ch.key_byte),
    .table_size      (table_size_r),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_status),
    .out_slot        (out_ch.slot),
    .out_probe_count (out_ch.probe_count),
    .out_keys_placed (out_ch.keys_placed),
    .out_probe_total (out_ch.probe_total)
  );

  assign out_ch.status = out_status;

endmodule

`default_nettype wire

[rtl/core/lph_ctrl.sv]
// Sequencer of the hash insert block: request intake, modulo, probe walk, clear sweep.
// Depends on lph_pkg; drives lph_dp through lph_cmd_t and reads lph_sts_t.
`default_nettype none

module lph_ctrl
  import lph_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_req_type,
  input  wire logic     in_last_byte,
  output logic          in_ready,
  input  wire lph_sts_t sts,
  output lph_cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_CLEAR     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_CHECK     = 7'b0000100,
    S_DIV       = 7'b0001000,
    S_PROBE_RD  = 7'b0010000,
    S_PROBE_CHK = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  state_t    state_r, state_nxt;
  res_code_t res_r, res_nxt;

  always_comb begin
    state_nxt       = state_r;
    res_nxt         = res_r;
    in_ready        = 1'b0;
    cmd             = '0;
    cmd.res         = res_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_req_type == REQ_CLEAR) begin
            cmd.clear_start = 1'b1;
            state_nxt       = S_CLEAR;
          end else begin
            cmd.key_load = 1'b1;
            if (in_last_byte) state_nxt = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.key_bad) begin
          res_nxt   = RES_BAD;
          state_nxt = S_DONE;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        state_nxt = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (!sts.slot_occ) begin
          res_nxt   = RES_PLACED;
          state_nxt = S_DONE;
        end else if (sts.probe_end) begin
          res_nxt   = RES_FULL;
          state_nxt = S_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PROBE_RD;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      res_r   <= RES_PLACED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear_start |=> state_r == S_CLEAR)
    else $error("clear request did not start the sweep");

  a_div_to_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> state_r == S_PROBE_RD)
    else $error("modulo finish did not start the probe walk");

  a_free_slot_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE_CHK && !sts.slot_occ) |=> (state_r == S_DONE && res_r == RES_PLACED))
    else $error("free slot did not lead to placement");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> state_r == S_IDLE)
    else $error("commit did not return to idle");

endmodule

`default_nettype wire

[rtl/core/lph_dp.sv]
// Datapath of the hash insert block: key accumulator, shift-subtract modulo unit,
// probe index/count, occupancy memory, running totals and the result register.
// Depends on lph_pkg; commanded by lph_ctrl.
`default_nettype none

module lph_dp
  import lph_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lph_cmd_t          cmd,
  output lph_sts_t               sts,
  input  wire logic [7:0]        in_key_byte,
  input  wire logic [SIZE_W-1:0] table_size,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output res_code_t              out_status,
  output logic [SLOT_W-1:0]      out_slot,
  output logic [SIZE_W-1:0]      out_probe_count,
  output logic [COUNT_W-1:0]     out_keys_placed,
  output logic [PSUM_W-1:0]      out_probe_total
);

  logic                 occ_mem [SLOTS];
  logic                 occ_q_r;

  logic [KEY_SUM_W-1:0] key_sum_r, key_sum_nxt;
  logic [KEY_LEN_W-1:0] key_len_r, key_len_nxt;
  logic                 key_bad_r, key_bad_nxt;
  logic [COUNT_W-1:0]   placed_r, placed_nxt;
  logic [PSUM_W-1:0]    psum_r, psum_nxt;
  logic [SLOT_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [SIZE_W-1:0]    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic [SLOT_W-1:0]    idx_r, idx_nxt;
  logic [SIZE_W-1:0]    n_r, n_nxt;

  logic                 out_valid_r, out_valid_nxt;
  res_code_t            out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic [SIZE_W-1:0]    out_probe_r, out_probe_nxt;
  logic [COUNT_W-1:0]   out_placed_r, out_placed_nxt;
  logic [PSUM_W-1:0]    out_psum_r, out_psum_nxt;

  logic [SIZE_W-1:0]    size_act;
  logic                 byte_ok;
  logic                 len_full;
  logic                 bad_pre;
  logic [SIZE_W-1:0]    rem_shift;
  logic [SIZE_W-1:0]    rem_step;
  logic [SIZE_W-1:0]    idx_inc;
  logic [COUNT_W-1:0]   placed_inc;
  logic [PSUM_W:0]      psum_add;
  logic [PSUM_W-1:0]    psum_inc;

  always_comb begin
    if (table_size == '0) begin
      size_act = SIZE_W'(1);
    end else if (table_size > SIZE_W'(SLOTS)) begin
      size_act = SIZE_W'(SLOTS);
    end else begin
      size_act = table_size;
    end
  end

  assign byte_ok    = (in_key_byte >= CHAR_A) && (in_key_byte <= CHAR_Z);
  assign len_full   = key_len_r >= KEY_LEN_W'(MAX_KEY_CHARS);
  assign bad_pre    = key_bad_r | len_full;
  assign rem_shift  = {rem_r[SLOT_W-1:0], key_sum_r[div_cnt_r]};
  assign rem_step   = (rem_shift >= size_act) ? rem_shift - size_act : rem_shift;
  assign idx_inc    = {1'b0, idx_r} + SIZE_W'(1);
  assign placed_inc = (placed_r == PLACED_MAX) ? placed_r : placed_r + COUNT_W'(1);
  assign psum_add   = {1'b0, psum_r} + (PSUM_W + 1)'(n_r);
  assign psum_inc   = (psum_add > {1'b0, PSUM_MAX}) ? PSUM_MAX : psum_add[PSUM_W-1:0];

  always_comb begin
    key_sum_nxt    = key_sum_r;
    key_len_nxt    = key_len_r;
    key_bad_nxt    = key_bad_r;
    placed_nxt     = placed_r;
    psum_nxt       = psum_r;
    clr_cnt_nxt    = clr_cnt_r;
    rem_nxt        = rem_r;
    div_cnt_nxt    = div_cnt_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_probe_nxt  = out_probe_r;
    out_placed_nxt = out_placed_r;
    out_psum_nxt   = out_psum_r;

    if (cmd.clear_start) begin
      key_sum_nxt = '0;
      key_len_nxt = '0;
      key_bad_nxt = 1'b0;
      placed_nxt  = '0;
      psum_nxt    = '0;
      clr_cnt_nxt = '0;
    end

    if (cmd.clr_step) clr_cnt_nxt = clr_cnt_r + SLOT_W'(1);

    if (cmd.key_load) begin
      if (!len_full) key_len_nxt = key_len_r + KEY_LEN_W'(1);
      if (byte_ok && !bad_pre) begin
        key_sum_nxt = key_sum_r + KEY_SUM_W'(in_key_byte - CHAR_BASE);
      end
      key_bad_nxt = bad_pre | !byte_ok;
    end

    if (cmd.div_start) begin
      rem_nxt     = '0;
      div_cnt_nxt = DIV_CNT_W'(KEY_SUM_W - 1);
    end

    if (cmd.div_step) begin
      rem_nxt     = rem_step;
      div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
      if (div_cnt_r == '0) begin
        idx_nxt = rem_step[SLOT_W-1:0];
        n_nxt   = SIZE_W'(1);
      end
    end

    if (cmd.probe_next) begin
      idx_nxt = (idx_inc == size_act) ? '0 : idx_inc[SLOT_W-1:0];
      n_nxt   = n_r + SIZE_W'(1);
    end

    if (cmd.commit) begin
      key_sum_nxt    = '0;
      key_len_nxt    = '0;
      key_bad_nxt    = 1'b0;
      out_valid_nxt  = 1'b1;
      out_status_nxt = cmd.res;
      out_slot_nxt   = '0;
      out_probe_nxt  = (cmd.res == RES_BAD) ? '0 : n_r;
      out_placed_nxt = placed_r;
      out_psum_nxt   = psum_r;
      if (cmd.res == RES_PLACED) begin
        placed_nxt     = placed_inc;
        psum_nxt       = psum_inc;
        out_slot_nxt   = idx_r;
        out_placed_nxt = placed_inc;
        out_psum_nxt   = psum_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_sum_r   <= '0;
      key_len_r   <= '0;
      key_bad_r   <= 1'b0;
      placed_r    <= '0;
      psum_r      <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      key_sum_r   <= key_sum_nxt;
      key_len_r   <= key_len_nxt;
      key_bad_r   <= key_bad_nxt;
      placed_r    <= placed_nxt;
      psum_r      <= psum_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    div_cnt_r    <= div_cnt_nxt;
    idx_r        <= idx_nxt;
    n_r          <= n_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_probe_r  <= out_probe_nxt;
    out_placed_r <= out_placed_nxt;
    out_psum_r   <= out_psum_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      occ_mem[clr_cnt_r] <= 1'b0;
    end else if (cmd.commit && cmd.res == RES_PLACED) begin
      occ_mem[idx_r] <= 1'b1;
    end
    occ_q_r <= occ_mem[idx_r];
  end

  assign sts.key_bad   = key_bad_r;
  assign sts.div_last  = (div_cnt_r == '0);
  assign sts.slot_occ  = occ_q_r;
  assign sts.probe_end = (n_r == size_act);
  assign sts.clr_last  = &clr_cnt_r;
  assign sts.out_busy  = out_valid_r && !out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_probe_count = out_probe_r;
  assign out_keys_placed = out_placed_r;
  assign out_probe_total = out_psum_r;

  a_placed_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cmd.res == RES_PLACED) |-> ({1'b0, idx_r} < size_act && n_r != '0))
    else $error("placement outside the active table");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && !cmd.commit) |=> (out_valid_r && $stable(out_psum_r)))
    else $error("stalled result changed");

  a_bad_no_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && cmd.res == RES_BAD) |=> (out_probe_r == '0 && out_slot_r == '0))
    else $error("bad key reported probes");

endmodule

`default_nettype wire

[dv/testbench.sv]
// Testbench for linear_probe_hash_insert: drives keys a byte per request, checks each outcome.
// A scoreboard class predicts slot, probe count and running totals from its own table copy.
// Depends on lph_pkg, lph_in_if, lph_out_if and the linear_probe_hash_insert top level.
`default_nettype none

module testbench;
  import lph_pkg::*;

  typedef struct {
    logic       req_type;
    logic [7:0] key_byte;
    logic       last_byte;
  } key_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [SIZE_W-1:0]   probe_count;
    logic [COUNT_W-1:0]  keys_placed;
    logic [PSUM_W-1:0]   probe_total;
  } key_result_t;

  typedef enum {RX_OPEN, RX_COIN, RX_CHOKED, RX_RHYTHM} rx_mode_t;

  class insert_scoreboard;
    logic [SIZE_W-1:0] table_size;
    bit                occupied [SLOTS];
    int                key_sum;
    int                key_len;
    bit                key_bad;
    int                placed;
    int                probe_sum;
    key_result_t       pending_outcomes [$];
    int                mismatches;

    function new();
      table_size = TABLE_SIZE_RST;
      mismatches = 0;
      clear_table();
    endfunction

    function void clear_key();
      key_sum = 0;
      key_len = 0;
      key_bad = 0;
    endfunction

    function void clear_table();
      foreach (occupied[i]) occupied[i] = 0;
      placed = 0;
      probe_sum = 0;
      clear_key();
    endfunction

    function int pending();
      return pending_outcomes.size();
    endfunction

    function void note_request(key_req_t r);
      int          size;
      int          idx;
      int          n;
      key_result_t res;
      if (r.req_type == REQ_CLEAR) begin
        clear_table();
        return;
      end
      if (key_len >= MAX_KEY_CHARS) key_bad = 1;
      else key_len++;
      if (r.key_byte < CHAR_A || r.key_byte > CHAR_Z) begin
        key_bad = 1;
      end else if (!key_bad) begin
        key_sum = (key_sum + int'(r.key_byte) - int'(CHAR_BASE)) % (1 << KEY_SUM_W);
      end
      if (!r.last_byte) return;
      res.slot = '0;
      res.probe_count = '0;
      if (key_bad) begin
        res.status = RES_BAD;
      end else begin
        size = int'(table_size);
        if (size == 0) size = 1;
        if (size > SLOTS) size = SLOTS;
        idx = key_sum % size;
        n = 1;
        while (occupied[idx] && n <= size) begin
          idx = (idx + 1) % size;
          n++;
        end
        if (n <= size) begin
          occupied[idx] = 1;
          res.status = RES_PLACED;
          res.slot = SLOT_W'(idx);
          res.probe_count = SIZE_W'(n);
          if (placed < int'(PLACED_MAX)) placed++;
          probe_sum = (probe_sum + n > int'(PSUM_MAX)) ? int'(PSUM_MAX) : probe_sum + n;
        end else begin
          res.status = RES_FULL;
          res.probe_count = SIZE_W'(size);
        end
      end
      res.keys_placed = COUNT_W'(placed);
      res.probe_total = PSUM_W'(probe_sum);
      clear_key();
      pending_outcomes.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH: %s", msg);
    endtask

    task check_result(key_result_t got);
      key_result_t exp;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result with no request waiting, status %0h slot %0d",
                                  got.status, got.slot));
        return;
      end
      exp = pending_outcomes.pop_front();
      if (got.status !== exp.status)
        report_mismatch($sformatf("status %0h, expected %0h", got.status, exp.status));
      if (got.slot !== exp.slot)
        report_mismatch($sformatf("slot %0d, expected %0d", got.slot, exp.slot));
      if (got.probe_count !== exp.probe_count)
        report_mismatch($sformatf("probe_count %0d, expected %0d",
                                  got.probe_count, exp.probe_count));
      if (got.keys_placed !== exp.keys_placed)
        report_mismatch($sformatf("keys_placed %0d, expected %0d",
                                  got.keys_placed, exp.keys_placed));
      if (got.probe_total !== exp.probe_total)
        report_mismatch($sformatf("probe_total %0d, expected %0d",
                                  got.probe_total, exp.probe_total));
    endtask

    task final_check();
      if (pending_outcomes.size() != 0)
        report_mismatch($sformatf("%0d expected results never arrived",
                                  pending_outcomes.size()));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  lph_in_if  in_ch ();
  lph_out_if out_ch ();

  insert_scoreboard sb = new();

  int burst_left = 0;
  int items_sent = 0;

  linear_probe_hash_insert dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    key_result_t got;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status = out_ch.status;
      got.slot = out_ch.slot;
      got.probe_count = out_ch.probe_count;
      got.keys_placed = out_ch.keys_placed;
      got.probe_total = out_ch.probe_total;
      sb.check_result(got);
    end
  end

  initial begin
    rx_mode_t mode;
    int       left;
    int       tick;
    out_ch.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 300);
      end
      left--;
      tick++;
      case (mode)
        RX_OPEN:   out_ch.ready = 1'b1;
        RX_COIN:   out_ch.ready = 1'($urandom_range(0, 1));
        RX_CHOKED: out_ch.ready = ($urandom_range(0, 7) == 0);
        default:   out_ch.ready = ((tick % 5) < 3);
      endcase
    end
  end

  task idle_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task send_item(logic rtype, logic [7:0] kbyte, logic last);
    key_req_t r;
    if (burst_left == 0) begin
      idle_gap(($urandom_range(0, 3) == 0) ? 0 :
               $urandom_range(1, ($urandom_range(0, 7) == 0) ? 20 : 4));
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    r.req_type = rtype;
    r.key_byte = kbyte;
    r.last_byte = last;
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.req_type = rtype;
    in_ch.key_byte = kbyte;
    in_ch.last_byte = last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(r);
    items_sent++;
  endtask

  task send_key(int len, int bad_pct);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < bad_pct) b = 8'($urandom_range(0, 255));
      else b = 8'($urandom_range(CHAR_A, CHAR_Z));
      send_item(REQ_KEY, b, i == len - 1);
    end
  endtask

  task drain_results(int extra);
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task cfg_write(logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CFG_AW'(int'(CFG_REG_TABLE_SIZE) * 4);
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    sb.table_size = data[SIZE_W-1:0];
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== CFG_DW'(data[SIZE_W-1:0]))
      sb.report_mismatch($sformatf("table_size reads 0x%0h, expected 0x%0h",
                                   prdata, data[SIZE_W-1:0]));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    int               phase_size [9];
    int               value;
    int               phase_end;
    int               pick;
    logic [CFG_DW-1:0] data;
    phase_size = '{1024, 1, 0, 2047, 2, 7, 1000, 1024, -1};
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_KEY;
    in_ch.key_byte = '0;
    in_ch.last_byte = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // small table: wraparound, full table, bad bytes, clear, overlong key
    cfg_write(CFG_DW'(3));
    repeat (3) send_item(REQ_KEY, CHAR_A, 1'b1);
    send_item(REQ_KEY, CHAR_A + 8'd1, 1'b1);
    send_item(REQ_KEY, CHAR_BASE, 1'b1);
    send_item(REQ_KEY, CHAR_Z + 8'd1, 1'b1);
    send_item(REQ_KEY, 8'h00, 1'b0);
    send_item(REQ_KEY, 8'hFF, 1'b1);
    send_item(REQ_CLEAR, 8'hFF, 1'b1);
    send_item(REQ_KEY, CHAR_Z, 1'b1);
    repeat (MAX_KEY_CHARS) send_item(REQ_KEY, CHAR_A, 1'b0);
    send_item(REQ_KEY, CHAR_A, 1'b1);

    for (int p = 0; p < 9; p++) begin
      drain_results(1200);
      value = (phase_size[p] < 0) ? $urandom_range(1, 1024) : phase_size[p];
      data = CFG_DW'(value);
      if (p % 3 == 1) data = data | (CFG_DW'($urandom) & ~CFG_DW'(PLACED_MAX));
      cfg_write(data);
      if ($urandom_range(0, 1)) send_item(REQ_CLEAR, 8'($urandom), 1'($urandom));
      phase_end = items_sent + 70;
      while (items_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_key(($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 5),
                   0);
        end else if (pick < 92) begin
          send_key($urandom_range(1, 6), 30);
        end else if (pick < 94) begin
          send_item(REQ_CLEAR, 8'($urandom), 1'($urandom));
        end else if (pick < 95) begin
          drain_results(0);
        end else begin
          send_item(REQ_KEY, 8'($urandom), 1'($urandom));
        end
      end
    end

    drain_results(1200);
    sb.final_check();
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
